FILE: src/dvs_pkg.sv
// ----------------------------------------------------------------------------
// dvs_pkg: shared types and constants for the descending value sorter
// Holds the value width, the default depth and the cell control struct.
// ----------------------------------------------------------------------------
package dvs_pkg;

  localparam int unsigned MaxItemsDef = 16;
  localparam int unsigned ValueW      = 32;

  typedef logic signed [ValueW-1:0] value_t;

  // Control broadcast from the sequencer to every cell
  typedef struct packed {
    logic load;   // insert the incoming beat into the chain
    logic shift;  // move every held value one cell toward the head
  } cell_ctrl_t;

endpackage

FILE: src/descending_value_sorter_unit.sv
// ----------------------------------------------------------------------------
// descending_value_sorter_unit: systolic insertion sorter, largest first
// Output: the first result shows in the cycle after the beat marked last is taken.
// Throughput: one input beat per cycle while loading; one result per cycle
//   while draining and the output is ready. The single chain takes no new
//   beat while draining; a run of N values drains min(N, MAX_ITEMS) results.
// Reset: fill count, overflow flag and drain state clear; cell values do not.
// ----------------------------------------------------------------------------
module descending_value_sorter_unit #(
  parameter int unsigned MAX_ITEMS = dvs_pkg::MaxItemsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [31:0] item_value
  input  logic        s_axis_tlast,  // item_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [31:0] sorted_value
  output logic        m_axis_tlast,  // sorted_last
  output logic        m_axis_tuser   // [0] overflow
);

  localparam int unsigned CntW = $clog2(MAX_ITEMS + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_ITEMS);
  localparam logic [CntW-1:0] CntOne = CntW'(1);

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] count_q;
  logic            drop_q;

  logic            in_acc, out_acc;
  logic            full;
  dvs_pkg::cell_ctrl_t ctrl;
  dvs_pkg::value_t new_value;

  dvs_pkg::value_t value_w [MAX_ITEMS];
  logic            gt_w    [MAX_ITEMS];

  assign s_axis_tready = (state_q == ST_LOAD);
  assign m_axis_tvalid = (state_q == ST_DRAIN);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = m_axis_tvalid && m_axis_tready;
  assign full          = (count_q == CntMax);
  assign new_value     = dvs_pkg::value_t'(s_axis_tdata);

  assign ctrl.load  = in_acc && !full;
  assign ctrl.shift = out_acc;

  // Build the chain of cells
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic            occ;
    logic            prev_gt;
    dvs_pkg::value_t prev_value, next_value;

    assign occ = (CntW'(i) < count_q);

    if (i == 0) begin : g_head
      assign prev_gt    = 1'b0;
      assign prev_value = value_w[i];
    end else begin : g_body
      assign prev_gt    = gt_w[i-1];
      assign prev_value = value_w[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign next_value = value_w[i];
    end else begin : g_inner
      assign next_value = value_w[i+1];
    end

    dvs_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occ_i        (occ),
      .new_value_i  (new_value),
      .prev_gt_i    (prev_gt),
      .prev_value_i (prev_value),
      .next_value_i (next_value),
      .gt_o         (gt_w[i]),
      .value_o      (value_w[i])
    );
  end

  // Sequence load and drain, track fill count and overflow
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      count_q <= '0;
      drop_q  <= 1'b0;
    end else begin
      case (state_q)
        ST_LOAD: begin
          if (in_acc) begin
            if (full) begin
              drop_q <= 1'b1;
            end else begin
              count_q <= count_q + CntOne;
            end
            if (s_axis_tlast) begin
              state_q <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (out_acc) begin
            count_q <= count_q - CntOne;
            if (count_q == CntOne) begin
              drop_q  <= 1'b0;
              state_q <= ST_LOAD;
            end
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

  // Present the head cell
  assign m_axis_tdata = 32'(value_w[0]);
  assign m_axis_tlast = (count_q == CntOne);
  assign m_axis_tuser = drop_q;

  // Draining always has at least one value left
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (count_q != '0))
    else $error("drain with empty chain");

  // The beat marked last starts the drain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tlast) |=> m_axis_tvalid)
    else $error("last beat did not start drain");

  // After the final result the chain is empty and overflow cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && m_axis_tlast) |=> (!m_axis_tvalid && count_q == '0 && !drop_q))
    else $error("chain not cleared after final result");

  // Fill count never exceeds the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntMax)
    else $error("fill count beyond depth");

endmodule

FILE: src/dvs_cell.sv
// ----------------------------------------------------------------------------
// dvs_cell: one cell of the insertion chain
// Holds one value. On load it compares the incoming beat with its value and
// takes the incoming value, its left neighbor's value, or keeps its own.
// On shift it takes its right neighbor's value.
// ----------------------------------------------------------------------------
module dvs_cell (
  input  logic               clk_i,
  input  dvs_pkg::cell_ctrl_t ctrl_i,
  input  logic               occ_i,       // cell holds a value of this run
  input  dvs_pkg::value_t    new_value_i, // incoming beat
  input  logic               prev_gt_i,   // incoming beat ranks above left cell
  input  dvs_pkg::value_t    prev_value_i,
  input  dvs_pkg::value_t    next_value_i,
  output logic               gt_o,
  output dvs_pkg::value_t    value_o
);

  dvs_pkg::value_t value_q, value_d;

  // Incoming beat ranks above this cell when the cell is empty or smaller
  assign gt_o = !occ_i || (new_value_i > value_q);

  // Select the next held value
  always_comb begin
    value_d = value_q;
    if (ctrl_i.load) begin
      if (prev_gt_i) begin
        value_d = prev_value_i;
      end else if (gt_o) begin
        value_d = new_value_i;
      end
    end else if (ctrl_i.shift) begin
      value_d = next_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for descending_value_sorter_unit
// Streams runs of signed values into the sorter, predicts each sorted run
// (largest first, last beat marked, overflow flag on every beat of a run that
// lost values) and checks every output beat in order. Both sides idle in
// random bursts, the output side stalls long enough to back up the input,
// and runs cover single values, extremes, duplicates and overflow.
// ----------------------------------------------------------------------------

// One expected output beat
typedef struct packed {
  dvs_pkg::value_t value;
  logic            last;
  logic            ovf;
} sorted_beat_t;

// Predicts sorted runs and checks output beats against them
class sort_scoreboard;
  int unsigned     depth;
  dvs_pkg::value_t run_values[$];
  bit              run_dropped;
  sorted_beat_t    sorted_due[$];
  int unsigned     error_count;

  function new(int unsigned depth_i);
    depth       = depth_i;
    run_dropped = 1'b0;
    error_count = 0;
  endfunction

  function int unsigned pending();
    return sorted_due.size();
  endfunction

  // Collect one input beat; on the last beat sort the run and queue it
  function void note_input(dvs_pkg::value_t v, logic last);
    dvs_pkg::value_t tmp;
    int unsigned     n;
    sorted_beat_t    beat;
    if (run_values.size() < depth) begin
      run_values.insert(run_values.size(), v);
    end else begin
      run_dropped = 1'b1;
    end
    if (last) begin
      n = run_values.size();
      // exchange sort, signed compare, largest first
      for (int unsigned a = 0; a < n; a++) begin
        for (int unsigned b = a + 1; b < n; b++) begin
          if (run_values[a] < run_values[b]) begin
            tmp           = run_values[a];
            run_values[a] = run_values[b];
            run_values[b] = tmp;
          end
        end
      end
      for (int unsigned k = 0; k < n; k++) begin
        beat.value = run_values[k];
        beat.last  = (k + 1 == n);
        beat.ovf   = run_dropped;
        sorted_due.insert(sorted_due.size(), beat);
      end
      run_values.delete();
      run_dropped = 1'b0;
    end
  endfunction

  task report_mismatch(string what);
    error_count++;
    $display("mismatch: %s", what);
  endtask

  // Compare one output beat with the oldest expectation
  task check_result(dvs_pkg::value_t v, logic last, logic ovf);
    sorted_beat_t e;
    if (sorted_due.size() == 0) begin
      report_mismatch($sformatf("unexpected beat value=%0d last=%0b ovf=%0b", v, last, ovf));
      return;
    end
    e = sorted_due.pop_front();
    if (v !== e.value) begin
      report_mismatch($sformatf("value %0d, expected %0d", v, e.value));
    end
    if (last !== e.last) begin
      report_mismatch($sformatf("tlast %0b, expected %0b (value %0d)", last, e.last, e.value));
    end
    if (ovf !== e.ovf) begin
      report_mismatch($sformatf("overflow %0b, expected %0b (value %0d)", ovf, e.ovf, e.value));
    end
  endtask
endclass

module tb;

  localparam int unsigned SortDepth      = dvs_pkg::MaxItemsDef;
  localparam int unsigned RandomItems    = 110;
  localparam int unsigned QuietAfter     = 90;
  localparam int unsigned LongHoldCycles = 200;
  localparam int unsigned DrainCycles    = 32;
  localparam int unsigned CycleLimit     = 200000;

  typedef enum int unsigned {ValFull, ValNarrow, ValEdge} value_mode_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  bit          quiet_phase   = 1'b0;
  bit          hold_off_req  = 1'b0;
  int unsigned beats_sent    = 0;
  int unsigned cycle_count   = 0;

  sort_scoreboard sorted_sb = new(SortDepth);

  descending_value_sorter_unit #(
    .MAX_ITEMS(SortDepth)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  // Clock and reset
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Watchdog
  initial begin
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
        $display("[descending_value_sorter_unit] ERROR");
        $finish;
      end
    end
  end

  // Monitor both sides; note inputs before checking outputs of the same edge
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        if (s_axis_tvalid && s_axis_tready) begin
          sorted_sb.note_input(s_axis_tdata, s_axis_tlast);
        end
        if (m_axis_tvalid && m_axis_tready) begin
          sorted_sb.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
        end
      end
    end
  end

  // Output ready: random bursts, one long hold-off on request, none when quiet
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  // Drop valid and idle; n sets how long
  task automatic sender_idle(int unsigned n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Offer one beat and hold it until accepted; valid stays high afterwards
  task automatic send_beat(dvs_pkg::value_t v, logic last);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  function automatic dvs_pkg::value_t pick_value(value_mode_e mode);
    case (mode)
      ValNarrow: return dvs_pkg::value_t'(int'($urandom_range(0, 6)) - 3);
      ValEdge: begin
        case ($urandom_range(0, 5))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'hFFFF_FFFF;
          4: return 32'h0000_0001;
          default: return $urandom;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // Send one run of len values, the final one marked last
  task automatic send_run(int unsigned len, value_mode_e mode);
    for (int unsigned i = 0; i < len; i++) begin
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
        sender_idle($urandom_range(1, 13));
      end
      send_beat(pick_value(mode), i == len - 1);
      beats_sent++;
    end
  endtask

  // Main sequence
  initial begin
    int unsigned len;
    int unsigned pick;
    wait (rst_ni);
    @(posedge clk_i);

    // single-value runs at both extremes
    send_beat(32'h7FFF_FFFF, 1'b1);
    send_beat(32'h8000_0000, 1'b1);
    // extremes mixed in one run
    send_beat(32'h0000_0000, 1'b0);
    send_beat(32'h7FFF_FFFF, 1'b0);
    send_beat(32'hFFFF_FFFF, 1'b0);
    send_beat(32'h8000_0000, 1'b0);
    send_beat(32'h0000_0001, 1'b1);
    // store full with duplicates; the beat marked last is dropped
    send_run(SortDepth + 1, ValNarrow);

    // pause until every sorted beat has come out
    sender_idle(1);
    while (sorted_sb.pending() != 0) @(posedge clk_i);

    // back up the output while the input keeps streaming
    hold_off_req = 1'b1;
    send_run(SortDepth, ValFull);
    while (beats_sent < RandomItems) begin
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        len = $urandom_range(1, 6);
      end else if (pick <= 7) begin
        len = $urandom_range(7, SortDepth);
      end else if (pick == 8) begin
        len = SortDepth;
      end else begin
        len = $urandom_range(SortDepth + 1, SortDepth + 4);
      end
      if (beats_sent >= QuietAfter) begin
        quiet_phase = 1'b1;
      end
      send_run(len, value_mode_e'($urandom_range(0, 2)));
    end

    // wait for the last run to drain, then a little longer
    sender_idle(1);
    while (sorted_sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sorted_sb.error_count == 0) begin
      $display("[descending_value_sorter_unit] OK");
    end else begin
      $display("[descending_value_sorter_unit] ERROR");
    end
    $finish;
  end

endmodule
